@@ rtl/mcac_pkg.sv @@
// ----------------------------------------------------------------------------
// Mip chain address calculator package
// Shared limits, register indexes, status codes and extent helpers.
// ----------------------------------------------------------------------------
package mcac_pkg;

	localparam int MAX_EXTENT      = 16384;
	localparam int MAX_PIXEL_BYTES = 16;
	localparam int MAX_LEVELS      = 15;

	localparam int EXT_W   = 15;
	localparam int BPP_W   = 5;
	localparam int LVL_W   = 4;
	localparam int REQ_W   = 7;
	localparam int BYTES_W = 33;
	localparam int AREA_W  = 2 * EXT_W;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BASE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_BASE_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_BPP         = 2'd2;
	localparam logic [1:0] CFG_LEVEL_COUNT = 2'd3;

	// Status codes.
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_BAD_DIMS   = 2'd1;
	localparam logic [1:0] STAT_BAD_FORMAT = 2'd2;
	localparam logic [1:0] STAT_BAD_LEVELS = 2'd3;

	// One level handed to the size pipeline.
	typedef struct packed {
		logic             valid;
		logic [LVL_W-1:0] level;
	} mcac_issue_t;

	// Byte size of one level coming back from the size pipeline.
	typedef struct packed {
		logic               valid;
		logic [LVL_W-1:0]   level;
		logic [BYTES_W-1:0] bytes;
	} mcac_size_t;

	// Base extent shifted down by the level, never below one.
	function automatic logic [EXT_W-1:0] extent_at(input logic [EXT_W-1:0] base,
		input logic [LVL_W-1:0] lv);
		logic [EXT_W-1:0] e;
		e = base >> lv;
		return (e == '0) ? EXT_W'(1) : e;
	endfunction

	// Number of levels down to a 1x1 image: one plus the index of the top set bit.
	function automatic logic [LVL_W-1:0] capacity_of(input logic [EXT_W-1:0] w,
		input logic [EXT_W-1:0] h);
		logic [EXT_W-1:0] m;
		logic [LVL_W-1:0] levels;
		m = (w > h) ? w : h;
		levels = LVL_W'(1);
		for (int i = 1; i < EXT_W; i++) begin
			if (m[i]) begin
				levels = LVL_W'(i + 1);
			end
		end
		return levels;
	endfunction

endpackage

@@ rtl/mcac_level_unit.sv @@
// ----------------------------------------------------------------------------
// Mip chain level size unit
// Two-stage pipeline that turns a level index into the byte size of that level.
// ----------------------------------------------------------------------------
module mcac_level_unit import mcac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [EXT_W-1:0]   base_width,
	input  logic [EXT_W-1:0]   base_height,
	input  logic [BPP_W-1:0]   bytes_per_pixel,
	input  mcac_issue_t        issue,
	output mcac_size_t         result
);

	logic [EXT_W-1:0]   ext_w;
	logic [EXT_W-1:0]   ext_h;
	logic [AREA_W-1:0]  area;
	logic [AREA_W+BPP_W-1:0] size_full;

	logic               valid_s1;
	logic [LVL_W-1:0]   level_s1;
	logic [AREA_W-1:0]  area_s1;
	logic               valid_s2;
	logic [LVL_W-1:0]   level_s2;
	logic [BYTES_W-1:0] bytes_s2;

	assign ext_w     = extent_at(base_width, issue.level);
	assign ext_h     = extent_at(base_height, issue.level);
	assign area      = AREA_W'(ext_w) * AREA_W'(ext_h);
	assign size_full = (AREA_W + BPP_W)'(area_s1) * (AREA_W + BPP_W)'(bytes_per_pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= issue.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		level_s1 <= issue.level;
		area_s1  <= area;
		level_s2 <= level_s1;
		bytes_s2 <= size_full[BYTES_W-1:0];
	end

	assign result.valid = valid_s2;
	assign result.level = level_s2;
	assign result.bytes = bytes_s2;

endmodule

@@ rtl/mip_chain_address_calculator.sv @@
// ----------------------------------------------------------------------------
// Mip chain address calculator
// Gives extent, offset and size of one mip level of a packed chain.
// ----------------------------------------------------------------------------
// Usage: write base_width, base_height, bytes_per_pixel and level_count through
// the cfg_we/cfg_index/cfg_data port while the block is idle. Each input
// transaction carries a signed requested_level; the block answers with one
// output transaction holding status, the clamped level, its width and height,
// its byte offset and size, the size of the whole chain and the level capacity.
// The level sizes come from one shared shift/multiply pipeline that takes one
// level per cycle; a bad configuration skips it and goes straight to the done
// state. in_stall is high from acceptance until the result has moved into the
// output register, so a new item is taken only once the last one has left for
// the output register. A stalled result holds in the output register while the
// next input is already accepted and worked on.
// Reset clears both channels and sets every configuration register to one.
// ----------------------------------------------------------------------------
module mip_chain_address_calculator import mcac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [EXT_W-1:0]   cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [REQ_W-1:0]   requested_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [LVL_W-1:0]   chosen_level,
	output logic [EXT_W-1:0]   level_width,
	output logic [EXT_W-1:0]   level_height,
	output logic [BYTES_W-1:0] level_offset,
	output logic [BYTES_W-1:0] level_bytes,
	output logic [BYTES_W-1:0] chain_bytes,
	output logic [LVL_W-1:0]   level_capacity
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]         state_q;
	logic [EXT_W-1:0]   base_width_q;
	logic [EXT_W-1:0]   base_height_q;
	logic [BPP_W-1:0]   bpp_q;
	logic [LVL_W-1:0]   level_count_q;

	logic               issue_act_q;
	logic [LVL_W-1:0]   issue_lv_q;
	logic [1:0]         status_q;
	logic [LVL_W-1:0]   cap_q;
	logic [LVL_W-1:0]   chosen_q;
	logic [BYTES_W-1:0] total_q;
	logic [BYTES_W-1:0] offset_q;
	logic [BYTES_W-1:0] lbytes_q;

	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [LVL_W-1:0]   out_chosen_q;
	logic [EXT_W-1:0]   out_width_q;
	logic [EXT_W-1:0]   out_height_q;
	logic [BYTES_W-1:0] out_offset_q;
	logic [BYTES_W-1:0] out_lbytes_q;
	logic [BYTES_W-1:0] out_total_q;
	logic [LVL_W-1:0]   out_cap_q;

	logic               in_accept;
	logic               dims_ok;
	logic [LVL_W-1:0]   cap;
	logic [1:0]         cfg_status;
	logic [LVL_W-1:0]   last_level;
	logic [LVL_W-1:0]   clamped;
	logic               out_free;
	mcac_issue_t        issue;
	mcac_size_t         size;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	assign dims_ok = (base_width_q != '0) && (base_height_q != '0) &&
		(int'(base_width_q) <= MAX_EXTENT) && (int'(base_height_q) <= MAX_EXTENT);
	assign cap = dims_ok ? capacity_of(base_width_q, base_height_q) : '0;

	always_comb begin
		if (!dims_ok) begin
			cfg_status = STAT_BAD_DIMS;
		end else if ((bpp_q == '0) || (int'(bpp_q) > MAX_PIXEL_BYTES)) begin
			cfg_status = STAT_BAD_FORMAT;
		end else if ((level_count_q == '0) || (level_count_q > cap) ||
			(int'(level_count_q) > MAX_LEVELS)) begin
			cfg_status = STAT_BAD_LEVELS;
		end else begin
			cfg_status = STAT_OK;
		end
	end

	assign last_level = level_count_q - LVL_W'(1);

	// Non-positive requests go to level zero, large ones to the last level.
	always_comb begin
		if (requested_level[REQ_W-1] || (requested_level == '0)) begin
			clamped = '0;
		end else if (requested_level >= REQ_W'(last_level)) begin
			clamped = last_level;
		end else begin
			clamped = requested_level[LVL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_width_q  <= EXT_W'(1);
			base_height_q <= EXT_W'(1);
			bpp_q         <= BPP_W'(1);
			level_count_q <= LVL_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BASE_WIDTH:  base_width_q  <= cfg_data;
				CFG_BASE_HEIGHT: base_height_q <= cfg_data;
				CFG_BPP:         bpp_q         <= cfg_data[BPP_W-1:0];
				CFG_LEVEL_COUNT: level_count_q <= cfg_data[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	assign issue.valid = issue_act_q;
	assign issue.level = issue_lv_q;

	mcac_level_unit u_level (
		.clk             (clk),
		.arst_n          (arst_n),
		.base_width      (base_width_q),
		.base_height     (base_height_q),
		.bytes_per_pixel (bpp_q),
		.issue           (issue),
		.result          (size)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_act_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (cfg_status == STAT_OK) begin
							state_q     <= ST_RUN;
							issue_act_q <= 1'b1;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RUN: begin
					if (issue_act_q && (issue_lv_q == last_level)) begin
						issue_act_q <= 1'b0;
					end
					if (size.valid && (size.level == last_level)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					issue_act_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_q   <= cfg_status;
			cap_q      <= cap;
			chosen_q   <= (cfg_status == STAT_OK) ? clamped : '0;
			issue_lv_q <= '0;
			total_q    <= '0;
			offset_q   <= '0;
			lbytes_q   <= '0;
		end else begin
			if (issue_act_q) begin
				issue_lv_q <= issue_lv_q + LVL_W'(1);
			end
			if (size.valid) begin
				total_q <= total_q + size.bytes;
				if (size.level == chosen_q) begin
					offset_q <= total_q;
					lbytes_q <= size.bytes;
				end
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			out_status_q <= status_q;
			out_chosen_q <= chosen_q;
			out_width_q  <= (status_q == STAT_OK) ? extent_at(base_width_q, chosen_q) : '0;
			out_height_q <= (status_q == STAT_OK) ? extent_at(base_height_q, chosen_q) : '0;
			out_offset_q <= offset_q;
			out_lbytes_q <= lbytes_q;
			out_total_q  <= total_q;
			out_cap_q    <= cap_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign chosen_level   = out_chosen_q;
	assign level_width    = out_width_q;
	assign level_height   = out_height_q;
	assign level_offset   = out_offset_q;
	assign level_bytes    = out_lbytes_q;
	assign chain_bytes    = out_total_q;
	assign level_capacity = out_cap_q;

endmodule

@@ rtl/mcac_checker.sv @@
// ----------------------------------------------------------------------------
// Mip chain address calculator checker
// Port-level checks on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module mcac_checker import mcac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         status,
	input  logic [EXT_W-1:0]   level_width,
	input  logic [EXT_W-1:0]   level_height,
	input  logic [BYTES_W-1:0] level_offset,
	input  logic [BYTES_W-1:0] level_bytes,
	input  logic [BYTES_W-1:0] chain_bytes
);

	// A stalled result transaction keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(chain_bytes) &&
			$stable(level_offset) && $stable(status))
		else $error("stalled result changed");

	// The block works on one item at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	// A rejected configuration reports no geometry.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != STAT_OK) |-> (chain_bytes == '0) &&
			(level_bytes == '0) && (level_width == '0) && (level_height == '0))
		else $error("geometry reported for bad configuration");

	// The chosen level lies inside the chain.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STAT_OK) |->
			({1'b0, level_offset} + {1'b0, level_bytes} <= {1'b0, chain_bytes}) &&
			(level_bytes != '0) && (level_width != '0) && (level_height != '0))
		else $error("level outside chain");

endmodule

bind mip_chain_address_calculator mcac_checker u_mcac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.level_width  (level_width),
	.level_height (level_height),
	.level_offset (level_offset),
	.level_bytes  (level_bytes),
	.chain_bytes  (chain_bytes)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Mip chain address calculator testbench
// Writes a series of image configurations, from the reset one through the
// largest chains and every invalid case, and sends requested levels under
// random idle and stall on both channels. A scoreboard predicts status,
// clamped level, extents, offsets, sizes and capacity for each accepted
// request and compares them with the block's results in order.
// ----------------------------------------------------------------------------
module tb_top import mcac_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]         status;
		logic [LVL_W-1:0]   chosen_level;
		logic [EXT_W-1:0]   width;
		logic [EXT_W-1:0]   height;
		logic [BYTES_W-1:0] offset;
		logic [BYTES_W-1:0] bytes;
		logic [BYTES_W-1:0] chain;
		logic [LVL_W-1:0]   capacity;
	} level_result_t;

	class mip_scoreboard;
		logic [EXT_W-1:0] width_cfg;
		logic [EXT_W-1:0] height_cfg;
		logic [BPP_W-1:0] bpp_cfg;
		logic [LVL_W-1:0] count_cfg;
		level_result_t    expected_q[$];
		int               errors;

		function new();
			width_cfg  = EXT_W'(1);
			height_cfg = EXT_W'(1);
			bpp_cfg    = BPP_W'(1);
			count_cfg  = LVL_W'(1);
			errors     = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [EXT_W-1:0] data);
			case (idx)
				CFG_BASE_WIDTH:  width_cfg  = data;
				CFG_BASE_HEIGHT: height_cfg = data;
				CFG_BPP:         bpp_cfg    = data[BPP_W-1:0];
				CFG_LEVEL_COUNT: count_cfg  = data[LVL_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned shrink(int unsigned base, int unsigned lv);
			int unsigned e;
			e = base >> lv;
			return (e == 0) ? 1 : e;
		endfunction

		function level_result_t predict_level(logic [REQ_W-1:0] req);
			level_result_t   r;
			int unsigned     top_ext;
			int unsigned     cap;
			int unsigned     last;
			int unsigned     pick;
			int              lvl;
			longint unsigned sz;
			longint unsigned running;
			bit              dims_ok;
			r = '0;
			dims_ok = width_cfg != 0 && height_cfg != 0 &&
				width_cfg <= MAX_EXTENT && height_cfg <= MAX_EXTENT;
			cap = 0;
			if (dims_ok) begin
				top_ext = 32'((width_cfg > height_cfg) ? width_cfg : height_cfg);
				cap = 1;
				while (top_ext > 1) begin
					top_ext >>= 1;
					cap++;
				end
			end
			r.capacity = cap[LVL_W-1:0];
			if (!dims_ok) begin
				r.status = STAT_BAD_DIMS;
			end else if (bpp_cfg == 0 || bpp_cfg > MAX_PIXEL_BYTES) begin
				r.status = STAT_BAD_FORMAT;
			end else if (count_cfg == 0 || count_cfg > cap || count_cfg > MAX_LEVELS) begin
				r.status = STAT_BAD_LEVELS;
			end else begin
				r.status = STAT_OK;
				last = 32'(count_cfg) - 1;
				lvl = int'($signed(req));
				if (lvl <= 0) begin
					pick = 0;
				end else if (lvl >= last) begin
					pick = last;
				end else begin
					pick = lvl;
				end
				// Walk the packed chain; the chosen level starts where the earlier ones end.
				running = 0;
				for (int lv = 0; lv < count_cfg; lv++) begin
					sz = 64'(shrink(32'(width_cfg), lv)) * 64'(shrink(32'(height_cfg), lv)) *
						64'(bpp_cfg);
					if (lv == pick) begin
						r.offset = running[BYTES_W-1:0];
						r.bytes  = sz[BYTES_W-1:0];
					end
					running += sz;
				end
				r.chain        = running[BYTES_W-1:0];
				r.chosen_level = pick[LVL_W-1:0];
				r.width        = EXT_W'(shrink(32'(width_cfg), pick));
				r.height       = EXT_W'(shrink(32'(height_cfg), pick));
			end
			return r;
		endfunction

		function void note_request(logic [REQ_W-1:0] req);
			expected_q = {expected_q, predict_level(req)};
		endfunction

		function void compare_field(string name, logic [BYTES_W-1:0] want,
			logic [BYTES_W-1:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(level_result_t got);
			level_result_t want;
			if (expected_q.size() == 0) begin
				$error("result transaction with no request outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", BYTES_W'(want.status), BYTES_W'(got.status));
			compare_field("chosen_level", BYTES_W'(want.chosen_level),
				BYTES_W'(got.chosen_level));
			compare_field("level_width", BYTES_W'(want.width), BYTES_W'(got.width));
			compare_field("level_height", BYTES_W'(want.height), BYTES_W'(got.height));
			compare_field("level_offset", want.offset, got.offset);
			compare_field("level_bytes", want.bytes, got.bytes);
			compare_field("chain_bytes", want.chain, got.chain);
			compare_field("level_capacity", BYTES_W'(want.capacity),
				BYTES_W'(got.capacity));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = CFG_BASE_WIDTH;
	logic [EXT_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [REQ_W-1:0]   requested_level = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [LVL_W-1:0]   chosen_level;
	logic [EXT_W-1:0]   level_width;
	logic [EXT_W-1:0]   level_height;
	logic [BYTES_W-1:0] level_offset;
	logic [BYTES_W-1:0] level_bytes;
	logic [BYTES_W-1:0] chain_bytes;
	logic [LVL_W-1:0]   level_capacity;

	bit            gaps_on = 1'b1;
	mip_scoreboard sb = new();

	mip_chain_address_calculator uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.requested_level(requested_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.chosen_level   (chosen_level),
		.level_width    (level_width),
		.level_height   (level_height),
		.level_offset   (level_offset),
		.level_bytes    (level_bytes),
		.chain_bytes    (chain_bytes),
		.level_capacity (level_capacity)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < 27);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_result(level_result_t'{status, chosen_level, level_width,
					level_height, level_offset, level_bytes, chain_bytes,
					level_capacity});
			end
			if (in_valid && !in_stall) begin
				sb.note_request(requested_level);
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic push_level(input logic [REQ_W-1:0] lvl);
		while (gaps_on && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		requested_level <= lvl;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	// Registers change only once every outstanding transaction has come back.
	task automatic load_config(input int unsigned w, input int unsigned h,
		input int unsigned bpp, input int unsigned cnt);
		logic [EXT_W-1:0] vals [4];
		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(negedge clk);
		end
		vals[CFG_BASE_WIDTH]  = EXT_W'(w);
		vals[CFG_BASE_HEIGHT] = EXT_W'(h);
		vals[CFG_BPP]         = EXT_W'(bpp);
		vals[CFG_LEVEL_COUNT] = EXT_W'(cnt);
		for (int i = CFG_BASE_WIDTH; i <= CFG_LEVEL_COUNT; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 2'(i);
			cfg_data <= vals[i];
			@(negedge clk);
			sb.write_reg(2'(i), vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Extent whose top set bit is top_bit, kept within the legal maximum.
	function automatic int unsigned extent_with_top(int unsigned top_bit);
		if (top_bit >= 14) begin
			return MAX_EXTENT;
		end
		return (1 << top_bit) | ($urandom & ((1 << top_bit) - 1));
	endfunction

	function automatic logic [REQ_W-1:0] pick_request();
		if ($urandom_range(1)) begin
			return REQ_W'(int'($urandom_range(16)) - 2);
		end
		return REQ_W'($urandom_range(127));
	endfunction

	task automatic random_phase(input int n);
		int unsigned w;
		int unsigned h;
		int unsigned bpp;
		int unsigned cnt;
		int unsigned s;
		int unsigned fault;
		cnt = $urandom_range(MAX_LEVELS, 1);
		s = $urandom_range(14, cnt - 1);
		w = extent_with_top(s);
		h = extent_with_top($urandom_range(s, 0));
		if ($urandom_range(1)) begin
			s = w;
			w = h;
			h = s;
		end
		bpp = $urandom_range(MAX_PIXEL_BYTES, 1);
		fault = $urandom_range(99);
		if (fault < 7) begin
			s = $urandom_range(1) ? 0 : $urandom_range(32767, MAX_EXTENT + 1);
			if ($urandom_range(1)) begin
				w = s;
			end else begin
				h = s;
			end
		end else if (fault < 13) begin
			bpp = $urandom_range(1) ? 0 : $urandom_range(31, MAX_PIXEL_BYTES + 1);
		end else if (fault < 20) begin
			if ($urandom_range(1)) begin
				cnt = 0;
			end else begin
				// More levels than the base size can hold.
				cnt = $urandom_range(MAX_LEVELS, 2);
				w = extent_with_top($urandom_range(cnt - 2, 0));
				h = extent_with_top($urandom_range(cnt - 2, 0));
			end
		end
		load_config(w, h, bpp, cnt);
		repeat (n) begin
			push_level(pick_request());
		end
	endtask

	initial begin
		int done;
		int n;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset configuration: a single 1x1 level.
		push_level(REQ_W'(-64));
		push_level(REQ_W'(63));
		push_level(REQ_W'(0));
		// Largest chain, then a one-pixel-high strip of full depth.
		load_config(MAX_EXTENT, MAX_EXTENT, MAX_PIXEL_BYTES, MAX_LEVELS);
		push_level(REQ_W'(0));
		push_level(REQ_W'(14));
		push_level(REQ_W'(7));
		push_level(REQ_W'(-1));
		push_level(REQ_W'(63));
		load_config(MAX_EXTENT, 1, MAX_PIXEL_BYTES, MAX_LEVELS);
		push_level(REQ_W'(14));
		// Bad dimensions: zero and above the limit.
		load_config(0, 5, 4, 1);
		push_level(REQ_W'(0));
		load_config(32767, MAX_EXTENT, 4, 1);
		push_level(REQ_W'(1));
		load_config(8, 0, 4, 1);
		push_level(REQ_W'(2));
		// Unknown formats.
		load_config(8, 8, 0, 2);
		push_level(REQ_W'(1));
		load_config(8, 8, 31, 2);
		push_level(REQ_W'(1));
		load_config(8, 8, MAX_PIXEL_BYTES + 1, 2);
		push_level(REQ_W'(1));
		// Level count zero, then one more than an 8x8 base allows.
		load_config(8, 8, 4, 0);
		push_level(REQ_W'(1));
		load_config(8, 8, 4, 5);
		push_level(REQ_W'(1));
		load_config(8, 8, 4, 4);
		push_level(REQ_W'(3));
		push_level(REQ_W'(4));
		push_level(REQ_W'(-64));

		done = 0;
		while (done < 1350) begin
			gaps_on = !(done >= 450 && done < 700);
			n = $urandom_range(40, 10);
			random_phase(n);
			done += n;
		end
		gaps_on = 1'b1;

		in_valid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/mcac_pkg.sv
rtl/mcac_level_unit.sv
rtl/mip_chain_address_calculator.sv
rtl/mcac_checker.sv
tb/tb_top.sv
